// ===== hw/rtl/skbh_pkg.sv =====
// skbh_pkg: shared types and constants for the string key bucket hash block.
// Used by every module under hw/rtl; depends on nothing else.

package skbh_pkg;

    // Hash word and rotate amount
    localparam int HashWidth = 32;
    localparam int RotLeft   = 27;
    localparam int ByteWidth = 8;

    // Configuration values and MAD product (16 x 32 product plus 16-bit offset)
    localparam int CfgWidth      = 16;
    localparam int CfgIndexWidth = 4;
    localparam int ProdWidth     = CfgWidth + HashWidth + 1;
    localparam int StepWidth     = $clog2(ProdWidth + 1);

    // Register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] CfgMadMultiplier = CfgIndexWidth'(0);
    localparam logic [CfgIndexWidth-1:0] CfgMadOffset     = CfgIndexWidth'(1);
    localparam logic [CfgIndexWidth-1:0] CfgMadPrime      = CfgIndexWidth'(2);
    localparam logic [CfgIndexWidth-1:0] CfgBucketCount   = CfgIndexWidth'(3);

    // Register values after reset
    localparam logic [CfgWidth-1:0] MadMultiplierReset = CfgWidth'(1);
    localparam logic [CfgWidth-1:0] MadOffsetReset     = CfgWidth'(0);
    localparam logic [CfgWidth-1:0] MadPrimeReset      = CfgWidth'(10007);
    localparam logic [CfgWidth-1:0] BucketCountReset   = CfgWidth'(1024);

    // Key byte transfer
    typedef struct packed {
        logic [ByteWidth-1:0] key_byte;
        logic                 last_byte;
    } skbh_in_t;

    // Result transfer
    typedef struct packed {
        logic [CfgWidth-1:0]  bucket_index;
        logic [HashWidth-1:0] key_hash;
    } skbh_out_t;

    // Request to the shared modulo unit
    typedef struct packed {
        logic                 start;
        logic [CfgWidth-1:0]  divisor;
        logic [ProdWidth-1:0] dividend;
    } skbh_red_req_t;

    // Answer from the shared modulo unit
    typedef struct packed {
        logic                done;
        logic [CfgWidth-1:0] remainder;
    } skbh_red_rsp_t;

    // One hash step: rotate left, then add the byte sign-extended
    function automatic logic [HashWidth-1:0] hash_step(
        input logic [HashWidth-1:0] h,
        input logic [ByteWidth-1:0] b
    );
        logic [HashWidth-1:0] rot;
        logic [HashWidth-1:0] ext;
        rot = (h << RotLeft) | (h >> (HashWidth - RotLeft));
        ext = {{(HashWidth - ByteWidth){b[ByteWidth-1]}}, b};
        return rot + ext;
    endfunction

endpackage

// ===== hw/rtl/string_key_bucket_hash.sv =====
// string_key_bucket_hash: top level with hash accumulator, MAD multiply and
// sequencer. Depends on skbh_pkg and skbh_modred.
//
// Usage:
//   Key channel (key_valid / key_stall / key_data) carries one key byte per
//   transfer with a last-byte flag. Bytes without the flag leave the block
//   ready again in the next cycle.
//   On a last byte the block computes bucket = ((a*h + b) mod p) mod buckets
//   with one multiply stage and a shared bit-serial modulo unit (one dividend
//   bit per cycle). key_stall stays high meanwhile.
//   Result channel (res_valid / res_stall / res_data) shows the raw hash and
//   bucket index when the multiply and modulo passes are done; a pass is
//   skipped if mad_prime or bucket_count is zero. The result sits in an output
//   register; the block takes bytes of the next key while it waits there.
//   If the receiver stalls, the result holds; a following key's computation
//   waits at its end until the output register is free.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; write it only while idle. Other indexes are ignored.
//   Reset clears the running hash, empties the result register and loads
//   the register defaults a=1, b=0, p=10007, buckets=1024.

module string_key_bucket_hash (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 key_valid,
    output logic                                 key_stall,
    input  skbh_pkg::skbh_in_t                   key_data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output skbh_pkg::skbh_out_t                  res_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [skbh_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [skbh_pkg::CfgWidth-1:0]        cfg_data
);

    // Sequencer codes
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul  = 3'd1;
    localparam logic [2:0] StSel  = 3'd2;
    localparam logic [2:0] StRedP = 3'd3;
    localparam logic [2:0] StRedB = 3'd4;
    localparam logic [2:0] StWait = 3'd5;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [skbh_pkg::HashWidth-1:0]    run_hash_reg;
    logic [skbh_pkg::HashWidth-1:0]    run_hash_next;
    logic [skbh_pkg::HashWidth-1:0]    key_hash_reg;
    logic [skbh_pkg::HashWidth-1:0]    key_hash_next;
    logic [skbh_pkg::ProdWidth-1:0]    prod_reg;
    logic [skbh_pkg::ProdWidth-1:0]    prod_next;
    logic [skbh_pkg::CfgWidth-1:0]     bucket_reg;
    logic [skbh_pkg::CfgWidth-1:0]     bucket_next;
    logic                              res_valid_reg;
    logic                              res_valid_next;
    skbh_pkg::skbh_out_t               res_data_reg;
    skbh_pkg::skbh_out_t               res_data_next;
    logic [skbh_pkg::CfgWidth-1:0]     mad_mult_reg;
    logic [skbh_pkg::CfgWidth-1:0]     mad_off_reg;
    logic [skbh_pkg::CfgWidth-1:0]     mad_prime_reg;
    logic [skbh_pkg::CfgWidth-1:0]     bucket_cnt_reg;
    logic [skbh_pkg::HashWidth-1:0]    hash_new;
    logic [skbh_pkg::ProdWidth-2:0]    mul_w;
    logic                              key_xfer;
    logic                              res_free;
    skbh_pkg::skbh_red_req_t           red_req;
    skbh_pkg::skbh_red_rsp_t           red_rsp;

    assign key_stall = (state_reg != StIdle);
    assign key_xfer  = key_valid && !key_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign hash_new  = skbh_pkg::hash_step(run_hash_reg, key_data.key_byte);

    // 16 x 32 multiply; the product plus the offset is registered in prod_reg
    assign mul_w = (skbh_pkg::ProdWidth-1)'(mad_mult_reg)
                 * (skbh_pkg::ProdWidth-1)'(key_hash_reg);

    // Shared modulo unit
    skbh_modred u_modred (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (red_req),
        .rsp   (red_rsp)
    );

    // Sequencer and datapath next values
    always_comb
    begin
        state_next       = state_reg;
        run_hash_next    = run_hash_reg;
        key_hash_next    = key_hash_reg;
        prod_next        = prod_reg;
        bucket_next      = bucket_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_data_next    = res_data_reg;
        red_req.start    = 1'b0;
        red_req.divisor  = mad_prime_reg;
        red_req.dividend = prod_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (key_xfer)
                begin
                    if (key_data.last_byte)
                    begin
                        key_hash_next = hash_new;
                        run_hash_next = '0;
                        state_next    = StMul;
                    end
                    else
                    begin
                        run_hash_next = hash_new;
                    end
                end
            end
            StMul:
            begin
                prod_next  = {1'b0, mul_w} + skbh_pkg::ProdWidth'(mad_off_reg);
                state_next = StSel;
            end
            StSel:
            begin
                priority if (mad_prime_reg != '0)
                begin
                    red_req.start = 1'b1;
                    state_next    = StRedP;
                end
                else if (bucket_cnt_reg == '0)
                begin
                    bucket_next = '0;
                    state_next  = StWait;
                end
                else
                begin
                    red_req.start   = 1'b1;
                    red_req.divisor = bucket_cnt_reg;
                    state_next      = StRedB;
                end
            end
            StRedP:
            begin
                red_req.dividend = skbh_pkg::ProdWidth'(red_rsp.remainder);
                red_req.divisor  = bucket_cnt_reg;
                if (red_rsp.done)
                begin
                    if (bucket_cnt_reg == '0)
                    begin
                        bucket_next = '0;
                        state_next  = StWait;
                    end
                    else
                    begin
                        red_req.start = 1'b1;
                        state_next    = StRedB;
                    end
                end
            end
            StRedB:
            begin
                if (red_rsp.done)
                begin
                    bucket_next = red_rsp.remainder;
                    state_next  = StWait;
                end
            end
            StWait:
            begin
                // load the output register once it is free
                if (res_free)
                begin
                    res_valid_next             = 1'b1;
                    res_data_next.bucket_index = bucket_reg;
                    res_data_next.key_hash     = key_hash_reg;
                    state_next                 = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            run_hash_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_hash_reg  <= run_hash_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_hash_reg <= key_hash_next;
        prod_reg     <= prod_next;
        bucket_reg   <= bucket_next;
        res_data_reg <= res_data_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mad_mult_reg   <= skbh_pkg::MadMultiplierReset;
            mad_off_reg    <= skbh_pkg::MadOffsetReset;
            mad_prime_reg  <= skbh_pkg::MadPrimeReset;
            bucket_cnt_reg <= skbh_pkg::BucketCountReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                skbh_pkg::CfgMadMultiplier: mad_mult_reg   <= cfg_data;
                skbh_pkg::CfgMadOffset:     mad_off_reg    <= cfg_data;
                skbh_pkg::CfgMadPrime:      mad_prime_reg  <= cfg_data;
                skbh_pkg::CfgBucketCount:   bucket_cnt_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== hw/rtl/skbh_modred.sv =====
// skbh_modred: bit-serial restoring modulo unit, one dividend bit per cycle.
// Depends on skbh_pkg for widths and the request/answer structs.

module skbh_modred (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skbh_pkg::skbh_red_req_t req,
    output skbh_pkg::skbh_red_rsp_t rsp
);

    logic                             run_reg;
    logic                             run_next;
    logic                             done_reg;
    logic                             done_next;
    logic [skbh_pkg::StepWidth-1:0]   count_reg;
    logic [skbh_pkg::StepWidth-1:0]   count_next;
    logic [skbh_pkg::ProdWidth-1:0]   dvd_reg;
    logic [skbh_pkg::ProdWidth-1:0]   dvd_next;
    logic [skbh_pkg::CfgWidth-1:0]    rem_reg;
    logic [skbh_pkg::CfgWidth-1:0]    rem_next;
    logic [skbh_pkg::CfgWidth-1:0]    div_reg;
    logic [skbh_pkg::CfgWidth-1:0]    div_next;
    logic [skbh_pkg::CfgWidth:0]      trial;
    logic [skbh_pkg::CfgWidth:0]      diff;

    // Shift in the next dividend bit and try to subtract the divisor
    assign trial = {rem_reg, dvd_reg[skbh_pkg::ProdWidth-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (req.start)
        begin
            run_next   = 1'b1;
            count_next = skbh_pkg::StepWidth'(skbh_pkg::ProdWidth);
            dvd_next   = req.dividend;
            rem_next   = '0;
            div_next   = req.divisor;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so 16 bits hold it
            rem_next   = (trial >= {1'b0, div_reg}) ? diff[skbh_pkg::CfgWidth-1:0]
                                                    : trial[skbh_pkg::CfgWidth-1:0];
            dvd_next   = dvd_reg << 1;
            count_next = count_reg - skbh_pkg::StepWidth'(1);
            if (count_reg == skbh_pkg::StepWidth'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/skbh_checker.sv =====
// skbh_checker: port-level assertions for string_key_bucket_hash, bound to it.
// Depends on skbh_pkg for the payload types.

module skbh_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                key_valid,
    input logic                key_stall,
    input skbh_pkg::skbh_in_t  key_data,
    input logic                res_valid,
    input logic                res_stall,
    input skbh_pkg::skbh_out_t res_data
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // A last-byte transfer starts the bucket computation
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && key_data.last_byte |=> key_stall)
        else $error("not busy after last byte");

    // After other bytes the block is ready again in the next cycle
    a_byte_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && !key_data.last_byte |=> !key_stall)
        else $error("stall after a plain byte");

    // A new result only comes out of a computation
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(key_stall))
        else $error("result without computation");

endmodule

bind string_key_bucket_hash skbh_checker u_skbh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_data  (key_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

// ===== tb/tb_string_key_bucket_hash.sv =====
// tb_string_key_bucket_hash: self-checking testbench for the string key bucket hash block.
// Streams random keys through string_key_bucket_hash under several MAD register settings and
// checks every hash and bucket index against a local model. Needs skbh_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_string_key_bucket_hash;

    // Idle time after the last result before registers are touched or the run ends
    localparam int SettleCycles = 120;
    localparam int MaxGap       = 18;
    localparam int HoldCycles   = 400;

    logic                               clk;
    logic                               rst_n;
    logic                               key_valid;
    logic                               key_stall;
    skbh_pkg::skbh_in_t                 key_data;
    logic                               res_valid;
    logic                               res_stall;
    skbh_pkg::skbh_out_t                res_data;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [skbh_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [skbh_pkg::CfgWidth-1:0]      cfg_data;

    // Local copy of the block state and registers
    logic [skbh_pkg::HashWidth-1:0] acc_hash;
    logic [skbh_pkg::CfgWidth-1:0]  mad_a;
    logic [skbh_pkg::CfgWidth-1:0]  mad_b;
    logic [skbh_pkg::CfgWidth-1:0]  mad_p;
    logic [skbh_pkg::CfgWidth-1:0]  buckets;

    skbh_pkg::skbh_out_t pending_results[$];
    skbh_pkg::skbh_out_t want;
    int                  mismatch_count;

    // Idle controls for both sides
    int unsigned tx_gap_max;
    int unsigned rx_gap_max;
    int unsigned rx_wait;
    int unsigned hold_req;
    int unsigned hold_left;

    string_key_bucket_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_data  (key_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ((a*h + b) mod p) mod buckets, exact on 64 bits
    function automatic logic [skbh_pkg::CfgWidth-1:0] mad_bucket(
        input logic [skbh_pkg::HashWidth-1:0] h
    );
        logic [63:0] v;
        v = 64'(mad_a) * 64'(h) + 64'(mad_b);
        if (mad_p != '0)
            v = v % 64'(mad_p);
        if (buckets == '0)
            return '0;
        return skbh_pkg::CfgWidth'(v % 64'(buckets));
    endfunction

    // Fold one accepted byte into the hash; a last byte yields one result
    task automatic absorb_key_byte(input logic [skbh_pkg::ByteWidth-1:0] b, input logic last);
        skbh_pkg::skbh_out_t r;
        acc_hash = {acc_hash[skbh_pkg::HashWidth-skbh_pkg::RotLeft-1:0],
                    acc_hash[skbh_pkg::HashWidth-1:skbh_pkg::HashWidth-skbh_pkg::RotLeft]};
        acc_hash = acc_hash + {{(skbh_pkg::HashWidth - skbh_pkg::ByteWidth)
                                {b[skbh_pkg::ByteWidth-1]}}, b};
        if (last)
        begin
            r.bucket_index = mad_bucket(acc_hash);
            r.key_hash     = acc_hash;
            pending_results.push_back(r);
            acc_hash = '0;
        end
    endtask

    // Offer one key byte after a random gap and wait for its transfer
    task automatic send_byte(input logic [skbh_pkg::ByteWidth-1:0] b, input logic last);
        int unsigned gap;
        gap = (tx_gap_max != 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            key_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        key_valid          = 1'b1;
        key_data.key_byte  = b;
        key_data.last_byte = last;
        do @(posedge clk); while (key_stall);
        absorb_key_byte(b, last);
    endtask

    task automatic send_key(input int unsigned len);
        for (int unsigned i = 1; i <= len; i++)
            send_byte(skbh_pkg::ByteWidth'($urandom_range(0, 255)), i == len);
    endtask

    // Sender pause: stop offering, let every result arrive, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        key_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_register(input logic [skbh_pkg::CfgIndexWidth-1:0] idx,
                                  input logic [skbh_pkg::CfgWidth-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            skbh_pkg::CfgMadMultiplier: mad_a = value;
            skbh_pkg::CfgMadOffset:     mad_b = value;
            skbh_pkg::CfgMadPrime:      mad_p = value;
            skbh_pkg::CfgBucketCount:   buckets = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Load all four registers plus a write to an index past the list
    task automatic apply_setting(input logic [skbh_pkg::CfgWidth-1:0] a,
                                 input logic [skbh_pkg::CfgWidth-1:0] b,
                                 input logic [skbh_pkg::CfgWidth-1:0] p,
                                 input logic [skbh_pkg::CfgWidth-1:0] n);
        wait_idle();
        write_register(skbh_pkg::CfgMadMultiplier, a);
        write_register(skbh_pkg::CfgMadOffset, b);
        write_register(skbh_pkg::CfgMadPrime, p);
        write_register(skbh_pkg::CfgBucketCount, n);
        write_register(skbh_pkg::CfgIndexWidth'(skbh_pkg::CfgBucketCount + 1
                                                + $urandom_range(0, 11)),
                       skbh_pkg::CfgWidth'($urandom_range(0, 65535)));
    endtask

    // Random keys: mostly short, some long, occasional single bytes
    task automatic send_random_keys(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                len = 1;
            else if (pick < 85)
                len = $urandom_range(2, 8);
            else
                len = $urandom_range(9, 40);
            send_key(len);
            sent += len;
        end
    endtask

    task automatic pick_idle_modes();
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
    endtask

    // Default registers: sign extension edges and rotation wrap
    task automatic test_directed_keys();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b1);
        for (int i = 0; i < 7; i++)
            send_byte(i[0] ? 8'h7F : 8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        wait_idle();
    endtask

    // Register extremes and the special settings, each with a batch of random keys
    task automatic test_register_sweep();
        logic [skbh_pkg::CfgWidth-1:0] settings[10][4];
        settings[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        settings[1] = '{16'd1, 16'd0, 16'd2, 16'd1};
        settings[2] = '{16'd0, 16'd5, 16'd7, 16'd3};         // zero multiplier
        settings[3] = '{16'd40000, 16'hFFFF, 16'd3, 16'd1000}; // offset above prime
        settings[4] = '{16'd12345, 16'd678, 16'd0, 16'd1000};  // prime of zero
        settings[5] = '{16'd12345, 16'd678, 16'd10007, 16'd0}; // no buckets
        settings[6] = '{16'd0, 16'd0, 16'd0, 16'd0};
        for (int i = 7; i < 10; i++)
            for (int j = 0; j < 4; j++)
                settings[i][j] = skbh_pkg::CfgWidth'($urandom_range(0, 65535));
        for (int i = 0; i < 10; i++)
        begin
            apply_setting(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
            pick_idle_modes();
            send_random_keys(150);
        end
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while bytes keep coming
    task automatic test_result_backpressure();
        apply_setting(16'd31, 16'd17, 16'd251, 16'd64);
        tx_gap_max = 0;
        rx_gap_max = MaxGap;
        @(negedge clk);
        hold_req = HoldCycles;
        for (int i = 0; i < 25; i++)
            send_key($urandom_range(1, 3));
        wait_idle();
    endtask

    // Long hold-off counter
    initial
    begin
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            else if (hold_left != 0)
                hold_left--;
        end
    end

    // Result stall driver
    initial
    begin
        forever
        begin
            @(negedge clk);
            res_stall = (hold_left != 0) || (rx_wait != 0);
            if (rx_wait != 0)
                rx_wait--;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transfer with none expected");
            else
            begin
                want = pending_results.pop_front();
                if (res_data.key_hash !== want.key_hash)
                    report_mismatch($sformatf("key_hash %h, want %h",
                                              res_data.key_hash, want.key_hash));
                if (res_data.bucket_index !== want.bucket_index)
                    report_mismatch($sformatf("bucket_index %0d, want %0d (hash %h)",
                                              res_data.bucket_index, want.bucket_index,
                                              want.key_hash));
            end
            rx_wait = (rx_gap_max != 0) ? $urandom_range(0, rx_gap_max) : 0;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        key_valid      = 1'b0;
        key_data       = '0;
        res_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        tx_gap_max     = 0;
        rx_gap_max     = 0;
        rx_wait        = 0;
        hold_req       = 0;
        mismatch_count = 0;
        acc_hash       = '0;
        mad_a          = skbh_pkg::MadMultiplierReset;
        mad_b          = skbh_pkg::MadOffsetReset;
        mad_p          = skbh_pkg::MadPrimeReset;
        buckets        = skbh_pkg::BucketCountReset;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_keys();
        test_register_sweep();
        test_result_backpressure();
        wait_idle();

        if (pending_results.size() != 0)
            report_mismatch("results still expected at end of run");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/skbh_pkg.sv
hw/rtl/skbh_modred.sv
hw/rtl/string_key_bucket_hash.sv
hw/rtl/skbh_checker.sv
tb/tb_string_key_bucket_hash.sv
